FILE: hdl/http_header_line_checker_defines.svh
// Assertion macros for the header line checker.
`ifndef HTTP_HEADER_LINE_CHECKER_DEFINES_SVH
`define HTTP_HEADER_LINE_CHECKER_DEFINES_SVH

`ifndef SYNTH
`define HHLC_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hhlc same-cycle check failed");
`define HHLC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hhlc next-cycle check failed");
`else
`define HHLC_ASSERT_SAME(lbl, ante, cons)
`define HHLC_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

FILE: hdl/hhlc_pkg.sv
// Shared types and byte constants for the header line checker.
package hhlc_pkg;

  localparam int FIELD_W = 10;

  localparam logic [7:0] CHAR_CR    = 8'h0D;
  localparam logic [7:0] CHAR_LF    = 8'h0A;
  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_SP    = 8'h20;
  localparam logic [7:0] CHAR_TAB   = 8'h09;

  localparam logic [1:0] COLONS_NONE = 2'd0;
  localparam logic [1:0] COLONS_ONE  = 2'd1;
  localparam logic [1:0] COLONS_MANY = 2'd2;

  typedef struct packed {
    logic               valid_res;
    logic [FIELD_W-1:0] name_length;
    logic [FIELD_W-1:0] value_offset;
    logic [FIELD_W-1:0] value_length;
  } line_res_t;

endpackage

FILE: hdl/http_header_line_checker.sv
// A line's result is registered and appears in the cycle after its last byte is accepted.
// The block takes one byte per cycle while the input is not stalled.
// The input stalls only while a finished result waits and the consumer is not ready.
// Reset (rst_n low, synchronous) clears the line state and drops any pending result.
// After every last byte the line state returns to its reset value.
`include "http_header_line_checker_defines.svh"
module http_header_line_checker
  import hhlc_pkg::*;
#(
  parameter int MAX_LINE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // line_byte[7:0]
  input  logic        in_tlast,
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // name_length[9:0], value_offset[19:10],
                                  // value_length[29:20], zero[31:30]
  output logic [0:0]  out_tuser   // valid_res[0]
);

  logic      take;
  logic      free;
  line_res_t scan_res;
  line_res_t held_res;

  assign in_tready = free;
  assign take      = in_tvalid && free;

  hhlc_scan #(
    .MAX_LINE(MAX_LINE)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .take     (take),
    .line_byte(in_tdata),
    .is_last  (in_tlast),
    .res      (scan_res)
  );

  hhlc_outreg u_outreg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (take && in_tlast),
    .res_in    (scan_res),
    .out_tready(out_tready),
    .out_tvalid(out_tvalid),
    .res_out   (held_res),
    .free      (free)
  );

  assign out_tdata = {2'b00, held_res.value_length, held_res.value_offset,
                      held_res.name_length};
  assign out_tuser = held_res.valid_res;

  `HHLC_ASSERT_NEXT(a_last_gives_result, in_tvalid && in_tready && in_tlast, out_tvalid)
  `HHLC_ASSERT_SAME(a_result_from_last, $rose(out_tvalid), $past(in_tvalid && in_tready && in_tlast))
  `HHLC_ASSERT_SAME(a_invalid_zero, out_tvalid && !out_tuser[0], out_tdata == 32'd0)

endmodule

FILE: hdl/hhlc_scan.sv
// Per-line scan state and the verdict computed on the last byte.
module hhlc_scan
  import hhlc_pkg::*;
#(
  parameter int MAX_LINE = 1024
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       take,
  input  logic [7:0] line_byte,
  input  logic       is_last,
  output line_res_t  res
);

  localparam int CNT_W = $clog2(MAX_LINE + 2);
  localparam int EXT_W = (CNT_W > FIELD_W) ? CNT_W : FIELD_W;
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_LINE);

  logic [CNT_W-1:0] byte_count_r, byte_count_nxt;
  logic             too_long_r, too_long_nxt;
  logic [1:0]       colon_count_r, colon_count_nxt;
  logic [CNT_W-1:0] colon_offset_r, colon_offset_nxt;
  logic             lead_r, lead_nxt;
  logic             trail_r, trail_nxt;
  logic [7:0]       held0_r, held0_nxt;
  logic [7:0]       held1_r, held1_nxt;
  logic             bad_start_r, bad_start_nxt;
  logic             seen_r, seen_nxt;
  logic [CNT_W-1:0] first_r, first_nxt;
  logic [CNT_W-1:0] last_r, last_nxt;

  logic [CNT_W-1:0] pos;
  logic             body_en;
  logic             blank;
  logic             ok;
  logic [CNT_W-1:0] trim_len;
  logic [CNT_W-1:0] empty_off;

  always_comb begin
    byte_count_nxt   = byte_count_r;
    too_long_nxt     = too_long_r;
    colon_count_nxt  = colon_count_r;
    colon_offset_nxt = colon_offset_r;
    lead_nxt         = lead_r;
    trail_nxt        = trail_r;
    bad_start_nxt    = bad_start_r;
    seen_nxt         = seen_r;
    first_nxt        = first_r;
    last_nxt         = last_r;
    pos              = byte_count_r - CNT_W'(2);
    body_en          = (byte_count_r >= CNT_W'(2)) && !too_long_r;
    blank            = (held0_r == CHAR_SP) || (held0_r == CHAR_TAB);

    if (body_en) begin
      if (held0_r == CHAR_COLON) begin
        if (colon_count_r == COLONS_NONE) begin
          colon_offset_nxt = pos;
        end
        if (colon_count_r != COLONS_MANY) begin
          colon_count_nxt = colon_count_r + 2'd1;
        end
      end else if (colon_count_r == COLONS_NONE) begin
        if ((pos == '0) && (held0_r == CHAR_SP)) begin
          lead_nxt = 1'b1;
        end
        trail_nxt = (held0_r == CHAR_SP);
      end else if (colon_count_r == COLONS_ONE) begin
        if ((pos == colon_offset_r + CNT_W'(1)) && !blank) begin
          bad_start_nxt = 1'b1;
        end
        if (!blank) begin
          if (!seen_r) begin
            first_nxt = pos;
            seen_nxt  = 1'b1;
          end
          last_nxt = pos;
        end
      end
    end

    held0_nxt = held1_r;
    held1_nxt = line_byte;
    if (byte_count_r <= MAX_CNT) begin
      byte_count_nxt = byte_count_r + CNT_W'(1);
    end
    too_long_nxt = too_long_r || (byte_count_nxt > MAX_CNT);
  end

  always_comb begin
    ok = !too_long_nxt && (byte_count_nxt > CNT_W'(2))
      && (held0_nxt == CHAR_CR) && (held1_nxt == CHAR_LF)
      && (colon_count_nxt == COLONS_ONE) && (colon_offset_nxt != '0)
      && !lead_nxt && !trail_nxt && !bad_start_nxt;
    trim_len  = last_nxt - first_nxt + CNT_W'(1);
    empty_off = byte_count_nxt - CNT_W'(2);
    res       = '0;
    if (ok) begin
      res.valid_res   = 1'b1;
      if (seen_nxt) begin
        res.value_offset = FIELD_W'(EXT_W'(first_nxt));
        res.value_length = FIELD_W'(EXT_W'(trim_len));
      end else begin
        res.value_offset = FIELD_W'(EXT_W'(empty_off));
        res.value_length = '0;
      end
      res.name_length = FIELD_W'(EXT_W'(colon_offset_nxt));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (take && is_last)) begin
      byte_count_r   <= '0;
      too_long_r     <= 1'b0;
      colon_count_r  <= COLONS_NONE;
      colon_offset_r <= '0;
      lead_r         <= 1'b0;
      trail_r        <= 1'b0;
      held0_r        <= '0;
      held1_r        <= '0;
      bad_start_r    <= 1'b0;
      seen_r         <= 1'b0;
      first_r        <= '0;
      last_r         <= '0;
    end else if (take) begin
      byte_count_r   <= byte_count_nxt;
      too_long_r     <= too_long_nxt;
      colon_count_r  <= colon_count_nxt;
      colon_offset_r <= colon_offset_nxt;
      lead_r         <= lead_nxt;
      trail_r        <= trail_nxt;
      held0_r        <= held0_nxt;
      held1_r        <= held1_nxt;
      bad_start_r    <= bad_start_nxt;
      seen_r         <= seen_nxt;
      first_r        <= first_nxt;
      last_r         <= last_nxt;
    end
  end

endmodule

FILE: hdl/hhlc_outreg.sv
// Result register with stream handshake toward the consumer.
module hhlc_outreg
  import hhlc_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      load,
  input  line_res_t res_in,
  input  logic      out_tready,
  output logic      out_tvalid,
  output line_res_t res_out,
  output logic      free
);

  logic      valid_r, valid_nxt;
  line_res_t res_r, res_nxt;

  always_comb begin
    free      = !valid_r || out_tready;
    valid_nxt = valid_r && !out_tready;
    res_nxt   = res_r;
    if (load) begin
      valid_nxt = 1'b1;
      res_nxt   = res_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
    res_r <= res_nxt;
  end

  assign out_tvalid = valid_r;
  assign res_out    = res_r;

endmodule

FILE: dv/http_header_line_checker_chk.sv
`timescale 1ns / 1ps
// Checker that predicts header line results from the input stream and compares them.
module http_header_line_checker_chk
  import hhlc_pkg::*;
#(
  parameter int MAX_LINE = 1024
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // line_byte[7:0]
  input  logic        in_tlast,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // name_length[9:0], value_offset[19:10],
                                  // value_length[29:20], zero[31:30]
  input  logic [0:0]  out_tuser,  // valid_res[0]
  output int          fail_count,
  output int          results_due
);

  localparam int CNT_W = $clog2(MAX_LINE + 2);

  logic [CNT_W-1:0] line_len;
  logic             overlong;
  logic [1:0]       colon_seen;
  logic [CNT_W-1:0] colon_pos;
  logic             name_lead_sp;
  logic             name_trail_sp;
  logic [7:0]       lag_byte [2];
  logic             val_bad_start;
  logic             val_has_text;
  logic [CNT_W-1:0] val_first;
  logic [CNT_W-1:0] val_last;

  line_res_t verdicts [$];
  int        mismatches = 0;
  int        due_cnt = 0;

  assign fail_count  = mismatches;
  assign results_due = due_cnt;

  function automatic logic blank_byte(input logic [7:0] b);
    return (b == CHAR_SP) || (b == CHAR_TAB);
  endfunction

  task automatic clear_line();
    line_len      = '0;
    overlong      = 1'b0;
    colon_seen    = COLONS_NONE;
    colon_pos     = '0;
    name_lead_sp  = 1'b0;
    name_trail_sp = 1'b0;
    lag_byte[0]   = '0;
    lag_byte[1]   = '0;
    val_bad_start = 1'b0;
    val_has_text  = 1'b0;
    val_first     = '0;
    val_last      = '0;
  endtask

  task automatic scan_body(input logic [7:0] b, input logic [CNT_W-1:0] pos);
    if (b == CHAR_COLON) begin
      if (colon_seen == COLONS_NONE) colon_pos = pos;
      if (colon_seen != COLONS_MANY) colon_seen = colon_seen + 2'd1;
    end else if (colon_seen == COLONS_NONE) begin
      if (pos == '0 && b == CHAR_SP) name_lead_sp = 1'b1;
      name_trail_sp = (b == CHAR_SP);
    end else if (colon_seen == COLONS_ONE) begin
      if (pos == colon_pos + 1'b1 && !blank_byte(b)) val_bad_start = 1'b1;
      if (!blank_byte(b)) begin
        if (!val_has_text) begin
          val_first    = pos;
          val_has_text = 1'b1;
        end
        val_last = pos;
      end
    end
  endtask

  // Each byte is examined two bytes late so that the closing CR LF never counts as body.
  task automatic take_byte(input logic [7:0] b, input logic last);
    line_res_t        want;
    logic [CNT_W-1:0] span;
    if (line_len >= 2 && !overlong) scan_body(lag_byte[0], line_len - 2'd2);
    lag_byte[0] = lag_byte[1];
    lag_byte[1] = b;
    if (line_len <= MAX_LINE) line_len = line_len + 1'b1;
    if (line_len > MAX_LINE) overlong = 1'b1;
    if (last) begin
      want = '0;
      if (!overlong && line_len > 2 && lag_byte[0] == CHAR_CR && lag_byte[1] == CHAR_LF &&
          colon_seen == COLONS_ONE && colon_pos != '0 && !name_lead_sp && !name_trail_sp &&
          !val_bad_start) begin
        want.valid_res   = 1'b1;
        want.name_length = FIELD_W'(colon_pos);
        if (val_has_text) begin
          span              = val_last - val_first + 1'b1;
          want.value_offset = FIELD_W'(val_first);
          want.value_length = FIELD_W'(span);
        end else begin
          want.value_offset = FIELD_W'(line_len - 2'd2);
        end
      end
      verdicts.push_back(want);
      clear_line();
    end
  endtask

  task automatic note_fail(input string what);
    if (mismatches < 10) $display("mismatch at %0t: %s", $realtime, what);
    mismatches++;
  endtask

  task automatic check_result();
    line_res_t want;
    line_res_t got;
    got.valid_res    = out_tuser[0];
    got.name_length  = out_tdata[FIELD_W-1:0];
    got.value_offset = out_tdata[2*FIELD_W-1:FIELD_W];
    got.value_length = out_tdata[3*FIELD_W-1:2*FIELD_W];
    if (verdicts.size() == 0) begin
      note_fail($sformatf("result with none pending: valid %0d name %0d voff %0d vlen %0d",
                          got.valid_res, got.name_length, got.value_offset,
                          got.value_length));
    end else begin
      want = verdicts.pop_front();
      if (got !== want || out_tdata[31:3*FIELD_W] !== '0) begin
        note_fail($sformatf({"expected valid %0d name %0d voff %0d vlen %0d, ",
                             "got valid %0d name %0d voff %0d vlen %0d pad %0h"},
                            want.valid_res, want.name_length, want.value_offset,
                            want.value_length, got.valid_res, got.name_length,
                            got.value_offset, got.value_length, out_tdata[31:3*FIELD_W]));
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_line();
      verdicts.delete();
    end else begin
      if (in_tvalid && in_tready) take_byte(in_tdata, in_tlast);
      if (out_tvalid && out_tready) check_result();
    end
    due_cnt <= verdicts.size();
  end

endmodule

FILE: dv/http_header_line_checker_tb.sv
`timescale 1ns / 1ps
// Testbench top that drives header lines into the checker block and reports the verdict.
module http_header_line_checker_tb;
  import hhlc_pkg::*;

  localparam int MAX_LINE     = 1024;
  localparam int RANDOM_BYTES = 880;
  localparam int CYCLE_LIMIT  = 400000;

  typedef enum int {
    LK_GOOD, LK_EMPTY_VALUE, LK_BLANK_VALUE, LK_LEAD_SP, LK_TRAIL_SP, LK_NO_COLON,
    LK_TWO_COLON, LK_NO_NAME, LK_BAD_START, LK_BAD_END, LK_SHORT, LK_NOISE
  } line_kind_t;

  typedef enum int {RX_OPEN, RX_HALF, RX_SPARSE, RX_BLOCK} rx_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = '0;   // line_byte[7:0]
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;       // name_length[9:0], value_offset[19:10],
                                // value_length[29:20], zero[31:30]
  logic [0:0]  out_tuser;       // valid_res[0]

  int          fail_count;
  int          results_due;
  int          cycles = 0;
  int          burst_left = 0;
  rx_mode_t    rx_mode = RX_OPEN;
  int          rx_left = 0;
  logic [7:0]  line_q [$];

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  http_header_line_checker #(
    .MAX_LINE(MAX_LINE)
  ) DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tlast  (in_tlast),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  http_header_line_checker_chk #(
    .MAX_LINE(MAX_LINE)
  ) u_chk (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .fail_count (fail_count),
    .results_due(results_due)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (rx_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(0, 3));
        rx_left = $urandom_range(4, 60);
      end
      rx_left--;
      case (rx_mode)
        RX_OPEN:   out_tready <= 1'b1;
        RX_HALF:   out_tready <= 1'($urandom_range(0, 1));
        RX_SPARSE: out_tready <= ($urandom_range(0, 3) == 0);
        default:   out_tready <= (rx_left < 3);
      endcase
    end
  end

  function automatic logic [7:0] text_byte(input bit allow_blank);
    logic [7:0] b;
    if (allow_blank && $urandom_range(0, 5) == 0) begin
      return $urandom_range(0, 1) ? CHAR_SP : CHAR_TAB;
    end
    do begin
      if ($urandom_range(0, 9) < 7) b = 8'($urandom_range(33, 126));
      else b = 8'($urandom_range(0, 255));
    end while (b == CHAR_COLON || (!allow_blank && (b == CHAR_SP || b == CHAR_TAB)));
    return b;
  endfunction

  task automatic add_text(input int n);
    for (int i = 0; i < n; i++) line_q.push_back(text_byte(i != 0 && i != n - 1));
  endtask

  task automatic add_blanks(input int n);
    repeat (n) line_q.push_back($urandom_range(0, 1) ? CHAR_SP : CHAR_TAB);
  endtask

  task automatic add_crlf();
    line_q.push_back(CHAR_CR);
    line_q.push_back(CHAR_LF);
  endtask

  task automatic push_byte(input logic [7:0] b, input logic last);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 40);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= b;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    burst_left--;
  endtask

  task automatic send_line();
    foreach (line_q[i]) push_byte(line_q[i], i == line_q.size() - 1);
  endtask

  task automatic send_text(input string s, input bit crlf);
    line_q.delete();
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
    if (crlf) add_crlf();
    send_line();
  endtask

  task automatic drain_results();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (results_due != 0);
  endtask

  task automatic build_line(input line_kind_t kind);
    int nlen;
    int vlen;
    nlen = $urandom_range(1, 10);
    vlen = $urandom_range(1, 16);
    line_q.delete();
    case (kind)
      LK_SHORT: begin
        if ($urandom_range(0, 1)) add_crlf();
        else repeat ($urandom_range(1, 2)) line_q.push_back(8'($urandom_range(0, 255)));
      end
      LK_NOISE: begin
        repeat ($urandom_range(1, 24)) begin
          case ($urandom_range(0, 7))
            0:       line_q.push_back(CHAR_COLON);
            1:       line_q.push_back(CHAR_CR);
            2:       line_q.push_back(CHAR_LF);
            3:       line_q.push_back(CHAR_SP);
            default: line_q.push_back(8'($urandom_range(0, 255)));
          endcase
        end
      end
      default: begin
        if (kind == LK_LEAD_SP) line_q.push_back(CHAR_SP);
        if (kind != LK_NO_NAME) add_text(nlen);
        if (kind == LK_TRAIL_SP) line_q.push_back(CHAR_SP);
        if (kind != LK_NO_COLON) line_q.push_back(CHAR_COLON);
        if (kind != LK_EMPTY_VALUE) begin
          if (kind != LK_BAD_START) add_blanks($urandom_range(1, 3));
          if (kind != LK_BLANK_VALUE) begin
            add_text(vlen);
            if (kind == LK_TWO_COLON) begin
              line_q.push_back(CHAR_COLON);
              add_text($urandom_range(1, 4));
            end
          end
          add_blanks($urandom_range(0, 3));
        end
        if (kind == LK_BAD_END) begin
          case ($urandom_range(0, 3))
            0: line_q.push_back(CHAR_CR);
            1: line_q.push_back(CHAR_LF);
            2: begin
              line_q.push_back(CHAR_LF);
              line_q.push_back(CHAR_CR);
            end
            default: begin
              line_q.push_back(CHAR_CR);
              line_q.push_back(CHAR_CR);
            end
          endcase
        end else begin
          add_crlf();
        end
      end
    endcase
  endtask

  initial begin
    int         rand_bytes;
    bit         drained_mid;
    int         r;
    int         total;
    line_kind_t kind;
    rand_bytes  = 0;
    drained_mid = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    line_q.delete();
    line_q.push_back(8'h00);
    send_line();
    send_text("", 1'b1);
    send_text("A:", 1'b1);
    line_q.delete();
    line_q.push_back("A");
    line_q.push_back(CHAR_COLON);
    line_q.push_back(CHAR_SP);
    line_q.push_back(8'h00);
    line_q.push_back(8'hFF);
    line_q.push_back(CHAR_TAB);
    add_crlf();
    send_line();
    send_text(" A:x", 1'b1);
    send_text("A :", 1'b1);
    send_text(":", 1'b1);
    send_text("A::", 1'b1);
    send_text("A\t: B ", 1'b1);
    line_q.delete();
    line_q.push_back("A");
    line_q.push_back(CHAR_COLON);
    line_q.push_back(CHAR_SP);
    line_q.push_back("B");
    line_q.push_back(CHAR_LF);
    line_q.push_back(CHAR_CR);
    send_line();
    drain_results();

    while (rand_bytes < RANDOM_BYTES) begin
      r = $urandom_range(0, 99);
      if (r < 45) kind = LK_GOOD;
      else if (r < 53) kind = LK_EMPTY_VALUE;
      else if (r < 58) kind = LK_BLANK_VALUE;
      else if (r < 62) kind = LK_LEAD_SP;
      else if (r < 66) kind = LK_TRAIL_SP;
      else if (r < 70) kind = LK_NO_COLON;
      else if (r < 74) kind = LK_TWO_COLON;
      else if (r < 78) kind = LK_NO_NAME;
      else if (r < 83) kind = LK_BAD_START;
      else if (r < 88) kind = LK_BAD_END;
      else if (r < 92) kind = LK_SHORT;
      else kind = LK_NOISE;
      build_line(kind);
      rand_bytes += line_q.size();
      send_line();
      if (!drained_mid && rand_bytes >= RANDOM_BYTES / 2) begin
        drained_mid = 1'b1;
        drain_results();
      end
    end

    // A line just past the length limit.
    total = MAX_LINE + $urandom_range(1, 4);
    line_q.delete();
    add_text(8);
    line_q.push_back(CHAR_COLON);
    line_q.push_back(CHAR_SP);
    add_text(total - 12);
    add_crlf();
    send_line();

    drain_results();
    repeat (8) @(posedge clk);
    if (fail_count == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule
